@@ hdl/chkv_pkg.sv @@
// Package for the chained hash key-value store: command and status codes and the hash seed.
// No dependencies.
`timescale 1ns / 1ps
package chkv_pkg;
	localparam logic [1:0] CMD_SET = 2'd0;
	localparam logic [1:0] CMD_GET = 2'd1;
	localparam logic [1:0] CMD_HAS = 2'd2;
	localparam logic [1:0] CMD_DEL = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_KEY_LONG = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOT_FND  = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam logic [31:0] HASH_START = 32'd5381;
endpackage

@@ hdl/chained_hash_key_value_store.sv @@
// Chained hash key-value store with a sequencer over one shared hash/modulo datapath.
// Depends on chkv_pkg and chkv_ram.
`timescale 1ns / 1ps
// One command word at a time; in_stall is high from the accepting edge until
// the result word has been taken. The key is hashed one byte per cycle, and a
// final hash step sees the end of the key. The hash is then reduced modulo
// the table size by a restoring subtractor at one quotient bit per cycle.
// The bucket head is read through S_HEAD, S_HEADW and S_WALK, and the chain
// is walked entry by entry, each with an address step and a registered read.
// An insert (S_INS1, S_INSW, S_INS2, S_INS3), an unlink (S_DEL1 to S_DEL4)
// and a get hit (S_GETW, S_GET) add states after the walk. A delete on an
// empty map skips the walk, and a key that is too long skips hashing and the
// walk. The result is held while out_stall is high. After reset a clearing
// pass fills the free stack and nulls the bucket heads before the first word
// is taken. Entry stores are single-port RAMs; a null link is held as the
// value ENTRIES.
module chained_hash_key_value_store #(
	parameter int ENTRIES   = 16,
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] key,
	input  logic [63:0] value,
	input  logic [3:0]  value_type,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        found,
	output logic [63:0] read_value,
	output logic [3:0]  read_type,
	output logic [4:0]  entry_count
);
	localparam int AW = $clog2(ENTRIES);
	localparam int LW = AW + 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	localparam logic [4:0] S_INIT = 5'd0, S_IDLE = 5'd1, S_HASH = 5'd2, S_MOD = 5'd3,
		S_HEAD = 5'd4, S_HEADW = 5'd5, S_WALK = 5'd6, S_WALKW = 5'd7, S_CMP = 5'd8,
		S_ACT = 5'd9, S_INS1 = 5'd10, S_INS2 = 5'd11, S_INS3 = 5'd12, S_DEL1 = 5'd13,
		S_DEL2 = 5'd14, S_DEL3 = 5'd15, S_DEL4 = 5'd16, S_OUT = 5'd17, S_GETW = 5'd18,
		S_GET = 5'd19, S_INSW = 5'd20, S_HOLD = 5'd21;

	logic [4:0]    state_q;
	logic [4:0]    tsize_q;
	logic [1:0]    cmd_q;
	logic [63:0]   key_q, val_q;
	logic [3:0]    typ_q;
	logic [3:0]    len_q, bi_q;
	logic [31:0]   h_q;
	logic [32:0]   rem_q;
	logic [5:0]    mi_q;
	logic [LW-1:0] node_q, prev_q, next_q, slot_q, pos_q;
	logic [AW-1:0] bkt_q, ini_q;
	logic [CW-1:0] used_q;
	logic [4:0]    steps_q;

	// RAM ports
	logic          k_we, v_we, t_we, n_we, p_we, b_we, f_we;
	logic [AW-1:0] k_a, v_a, t_a, n_a, p_a, b_a, f_a;
	logic [63:0]   k_wd, k_rd, v_wd, v_rd;
	logic [3:0]    t_wd, t_rd;
	logic [LW-1:0] n_wd, n_rd, p_wd, p_rd, b_wd, b_rd;
	logic [AW-1:0] f_wd, f_rd;

	chkv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_keys (.clk, .we(k_we), .addr(k_a),
		.wdata(k_wd), .rdata(k_rd));
	chkv_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_vals (.clk, .we(v_we), .addr(v_a),
		.wdata(v_wd), .rdata(v_rd));
	chkv_ram #(.WIDTH(4), .DEPTH(ENTRIES)) u_typs (.clk, .we(t_we), .addr(t_a),
		.wdata(t_wd), .rdata(t_rd));
	chkv_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (.clk, .we(n_we), .addr(n_a),
		.wdata(n_wd), .rdata(n_rd));
	chkv_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prev (.clk, .we(p_we), .addr(p_a),
		.wdata(p_wd), .rdata(p_rd));
	chkv_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_head (.clk, .we(b_we), .addr(b_a),
		.wdata(b_wd), .rdata(b_rd));
	chkv_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_free (.clk, .we(f_we), .addr(f_a),
		.wdata(f_wd), .rdata(f_rd));

	// effective table size: zero acts as one, clamp at ENTRIES
	logic [CW-1:0] size_eff;
	always_comb begin
		if (tsize_q == 5'd0) size_eff = CW'(1);
		else if (32'(tsize_q) > ENTRIES) size_eff = CW'(ENTRIES);
		else size_eff = CW'(tsize_q);
	end

	// key length and masking of the incoming word
	logic [3:0]  in_len;
	logic [63:0] in_key_m;
	always_comb begin
		in_len = 4'd8;
		for (int i = 7; i >= 0; i--) begin
			if (key[8*i +: 8] == 8'd0) in_len = 4'(i);
		end
		for (int i = 0; i < 8; i++) begin
			in_key_m[8*i +: 8] = (4'(i) < in_len) ? key[8*i +: 8] : 8'd0;
		end
	end

	logic [32:0] rem_sh;
	assign rem_sh = {rem_q[31:0], h_q[31]};

	logic [AW-1:0] used_idx, used_m1_idx;
	assign used_idx    = AW'(used_q);
	assign used_m1_idx = AW'(used_q - CW'(1));

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		k_we = 1'b0; v_we = 1'b0; t_we = 1'b0; n_we = 1'b0; p_we = 1'b0; b_we = 1'b0;
		f_we = 1'b0;
		k_a = AW'(node_q); v_a = AW'(node_q); t_a = AW'(node_q); n_a = AW'(node_q);
		p_a = AW'(node_q); b_a = bkt_q; f_a = used_idx;
		k_wd = key_q; v_wd = val_q; t_wd = typ_q; n_wd = NIL; p_wd = NIL;
		b_wd = NIL; f_wd = ini_q;
		case (state_q)
			S_INIT: begin
				b_we = 1'b1; b_a = ini_q; f_we = 1'b1; f_a = ini_q;
			end
			S_ACT: begin
				v_a = AW'(pos_q); t_a = AW'(pos_q);
				if (cmd_q == chkv_pkg::CMD_SET && pos_q != NIL) begin
					v_we = 1'b1; t_we = 1'b1;
				end
			end
			S_INS2: begin
				k_we = 1'b1; v_we = 1'b1; t_we = 1'b1; n_we = 1'b1; p_we = 1'b1;
				k_a = AW'(slot_q); v_a = AW'(slot_q); t_a = AW'(slot_q);
				n_a = AW'(slot_q); p_a = AW'(slot_q);
				n_wd = next_q; p_wd = NIL;
				b_we = 1'b1; b_wd = slot_q;
			end
			S_INS3: begin
				p_we = (next_q != NIL); p_a = AW'(next_q); p_wd = slot_q;
			end
			S_DEL1: begin
				n_a = AW'(pos_q); p_a = AW'(pos_q);
			end
			S_DEL3: begin
				if (prev_q != NIL) begin
					n_we = 1'b1; n_a = AW'(prev_q); n_wd = next_q;
				end else begin
					b_we = 1'b1; b_wd = next_q;
				end
			end
			S_DEL4: begin
				p_we = (next_q != NIL); p_a = AW'(next_q); p_wd = prev_q;
				v_we = 1'b1; t_we = 1'b1; v_a = AW'(pos_q); t_a = AW'(pos_q);
				v_wd = 64'd0; t_wd = 4'd0;
				f_we = 1'b1; f_a = used_m1_idx; f_wd = AW'(pos_q);
			end
			S_OUT: begin
				// unlink clears the links of the freed slot
				if (cmd_q == chkv_pkg::CMD_DEL && status == chkv_pkg::ST_OK &&
						pos_q != NIL) begin
					n_we = 1'b1; p_we = 1'b1; n_a = AW'(pos_q); p_a = AW'(pos_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT; tsize_q <= 5'd16; ini_q <= '0; used_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) tsize_q <= cfg_wdata;
			case (state_q)
				S_INIT: begin
					ini_q <= ini_q + AW'(1);
					if (ini_q == AW'(ENTRIES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command; key_q <= in_key_m; val_q <= value;
						typ_q <= value_type; len_q <= in_len; bi_q <= '0;
						h_q <= chkv_pkg::HASH_START; pos_q <= NIL;
						found <= 1'b0; read_value <= '0; read_type <= '0;
						status <= chkv_pkg::ST_OK;
						if (32'(in_len) >= KEY_BYTES) begin
							status <= chkv_pkg::ST_KEY_LONG; state_q <= S_OUT;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					// one key byte per cycle: h = h*33 + byte
					if (bi_q == len_q) begin
						rem_q <= '0; mi_q <= '0; state_q <= S_MOD;
					end else begin
						h_q <= (h_q << 5) + h_q + 32'(key_q[8*bi_q +: 8]);
						bi_q <= bi_q + 4'd1;
					end
				end
				S_MOD: begin
					// restoring remainder, one bit a cycle
					h_q <= h_q << 1;
					if (rem_sh >= 33'(size_eff)) rem_q <= rem_sh - 33'(size_eff);
					else rem_q <= rem_sh;
					mi_q <= mi_q + 6'd1;
					if (mi_q == 6'd31) state_q <= S_HEAD;
				end
				S_HEAD: begin
					bkt_q <= AW'(rem_q);
					if (cmd_q == chkv_pkg::CMD_DEL && used_q == '0) begin
						status <= chkv_pkg::ST_EMPTY; state_q <= S_OUT;
					end else begin
						state_q <= S_HEADW;
					end
				end
				S_HEADW: state_q <= S_WALK;  // head read in flight
				S_WALK: begin
					node_q <= b_rd; next_q <= b_rd; steps_q <= '0;
					state_q <= (b_rd == NIL) ? S_ACT : S_WALKW;
				end
				S_WALKW: state_q <= S_CMP;
				S_CMP: begin
					if (k_rd == key_q) begin
						pos_q <= node_q; found <= 1'b1; state_q <= S_ACT;
					end else if (n_rd == NIL || 32'(steps_q) >= ENTRIES - 1) begin
						state_q <= S_ACT;
					end else begin
						node_q <= n_rd; steps_q <= steps_q + 5'd1; state_q <= S_WALKW;
					end
				end
				S_ACT: begin
					case (cmd_q)
						chkv_pkg::CMD_SET: begin
							if (pos_q != NIL) state_q <= S_OUT;
							else if (used_q >= size_eff) begin
								status <= chkv_pkg::ST_FULL; state_q <= S_OUT;
							end else state_q <= S_INS1;
						end
						chkv_pkg::CMD_GET: begin
							if (pos_q != NIL) state_q <= S_GETW;
							else begin
								status <= chkv_pkg::ST_NOT_FND; state_q <= S_OUT;
							end
						end
						chkv_pkg::CMD_DEL: begin
							if (pos_q != NIL) state_q <= S_DEL1;
							else begin
								status <= chkv_pkg::ST_NOT_FND; state_q <= S_OUT;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_GETW: state_q <= S_GET;
				S_GET: begin
					read_value <= v_rd; read_type <= t_rd; state_q <= S_OUT;
				end
				S_INS1: state_q <= S_INSW;  // free stack read in flight
				S_INSW: begin
					slot_q <= {1'b0, f_rd};
					next_q <= b_rd;
					state_q <= S_INS2;
				end
				S_INS2: state_q <= S_INS3;
				S_INS3: begin
					used_q <= used_q + CW'(1); state_q <= S_OUT;
				end
				S_DEL1: state_q <= S_DEL2;
				S_DEL2: begin
					prev_q <= p_rd; next_q <= n_rd; state_q <= S_DEL3;
				end
				S_DEL3: state_q <= S_DEL4;
				S_DEL4: begin
					used_q <= used_q - CW'(1); state_q <= S_OUT;
				end
				S_OUT: begin
					entry_count <= 5'(used_q);
					out_valid <= 1'b1;
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					// hold the word until the sink takes it
					if (!out_stall) begin
						out_valid <= 1'b0; state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hdl/chkv_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module chkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
